FILE: hw/rtl/orbd_pkg.sv
`timescale 1ns / 1ps

package orbd_pkg;

    // Frame layout
    localparam int HDR_BYTES       = 4;
    localparam int ANALOG_BYTES    = 4;
    localparam int BINARY_BYTES    = 1;
    localparam int RAW_VALUE_BYTES = 16;
    localparam int VALUE_LANES     = 16;

    // Type codes at or below these limits select the short value forms
    localparam logic [7:0] ANALOG_TYPE_MAX = 8'd2;
    localparam logic [7:0] BINARY_TYPE_MAX = 8'd5;

    // Result kinds
    localparam logic KIND_OBJECT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Reset value of the object count clamp
    localparam logic [7:0] MAX_OBJECTS_RESET = 8'd255;

    typedef struct packed {
        logic        kind;
        logic [15:0] rec_id;
        logic [7:0]  rec_type;
        logic [7:0]  object_flags;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [7:0]  parsed_total;
        logic        end_of_run;
    } result_t;

    // Results caused by one accepted byte: count (0..2), first and second
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Header plus value length for a given type byte
    function automatic logic [5:0] frame_bytes(input logic [7:0] type_byte);
        logic [5:0] len;
        if (type_byte <= ANALOG_TYPE_MAX) begin
            len = 6'(ANALOG_BYTES);
        end else if (type_byte <= BINARY_TYPE_MAX) begin
            len = 6'(BINARY_BYTES);
        end else begin
            len = 6'(RAW_VALUE_BYTES);
        end
        return 6'(HDR_BYTES) + len;
    endfunction

endpackage

FILE: hw/rtl/orbd_parser.sv
`timescale 1ns / 1ps

module orbd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          in_accept,
    input  logic [7:0]    byte_in,
    input  logic          last_byte,
    output orbd_pkg::push_t push
);
    import orbd_pkg::*;

    localparam logic [1:0] PH_COUNT   = 2'd0;
    localparam logic [1:0] PH_OBJECTS = 2'd1;
    localparam logic [1:0] PH_DRAIN   = 2'd2;

    logic [7:0]  max_objects_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  objects_left_reg, objects_left_next;
    logic [4:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] header_reg, header_next;
    logic [127:0] value_reg, value_next;
    logic [7:0]  parsed_reg, parsed_next;

    logic [31:0]  hdr_cur;
    logic [127:0] val_cur;
    logic [5:0]   pos_inc;
    logic [4:0]   val_off;
    logic [7:0]   clamped;
    logic         obj_done;
    result_t      obj_res;
    result_t      sum_res;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_objects_reg <= MAX_OBJECTS_RESET;
        end else if (cfg_we) begin
            max_objects_reg <= cfg_wdata;
        end
    end

    // Next-state logic for one byte
    always_comb begin
        phase_next        = phase_reg;
        objects_left_next = objects_left_reg;
        byte_pos_next     = byte_pos_reg;
        parsed_next       = parsed_reg;
        obj_done          = 1'b0;

        clamped = (byte_in > max_objects_reg) ? max_objects_reg : byte_in;
        pos_inc = {1'b0, byte_pos_reg} + 6'd1;
        val_off = byte_pos_reg - 5'(HDR_BYTES);

        // header and value restart at the first byte of each object
        hdr_cur = (byte_pos_reg == 5'd0) ? '0 : header_reg;
        val_cur = (byte_pos_reg == 5'd0) ? '0 : value_reg;

        header_next = hdr_cur;
        value_next  = val_cur;
        if (byte_pos_reg < 5'(HDR_BYTES)) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                if (byte_pos_reg[1:0] == 2'(i)) begin
                    header_next[8*i +: 8] = hdr_cur[8*i +: 8] | byte_in;
                end
            end
        end else begin
            for (int j = 0; j < VALUE_LANES; j++) begin
                if (val_off[3:0] == 4'(j)) begin
                    value_next[8*j +: 8] = val_cur[8*j +: 8] | byte_in;
                end
            end
        end

        unique case (phase_reg)
            PH_COUNT: begin
                objects_left_next = clamped;
                byte_pos_next     = '0;
                parsed_next       = '0;
                phase_next        = (clamped == 8'd0) ? PH_DRAIN : PH_OBJECTS;
            end
            PH_OBJECTS: begin
                if (pos_inc >= 6'(HDR_BYTES) && pos_inc >= frame_bytes(header_next[23:16]))
                begin
                    obj_done          = 1'b1;
                    parsed_next       = parsed_reg + 8'd1;
                    objects_left_next = objects_left_reg - 8'd1;
                    byte_pos_next     = '0;
                    if (objects_left_reg == 8'd1) begin
                        phase_next = PH_DRAIN;
                    end
                end else begin
                    byte_pos_next = pos_inc[4:0];
                end
            end
            default: begin
                // draining or unused code: byte ignored
            end
        endcase

        if (last_byte) begin
            phase_next        = PH_COUNT;
            objects_left_next = '0;
            byte_pos_next     = '0;
        end
    end

    // Result records
    always_comb begin
        obj_res              = '0;
        obj_res.kind         = KIND_OBJECT;
        obj_res.rec_id       = header_next[15:0];
        obj_res.rec_type     = header_next[23:16];
        obj_res.object_flags = header_next[31:24];
        obj_res.value_low    = value_next[63:0];
        obj_res.value_high   = value_next[127:64];
        obj_res.end_of_run   = !last_byte;

        sum_res              = '0;
        sum_res.kind         = KIND_SUMMARY;
        sum_res.parsed_total = parsed_next;
        sum_res.end_of_run   = 1'b1;

        push.n  = in_accept ? (2'(obj_done) + 2'(last_byte)) : 2'd0;
        push.r0 = obj_done ? obj_res : sum_res;
        push.r1 = sum_res;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_COUNT;
            objects_left_reg <= '0;
            byte_pos_reg     <= '0;
            parsed_reg       <= '0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            objects_left_reg <= objects_left_next;
            byte_pos_reg     <= byte_pos_next;
            parsed_reg       <= last_byte ? 8'd0 : parsed_next;
        end
    end

    // Header and value bytes are rebuilt from scratch for every object
    always_ff @(posedge aclk) begin
        if (in_accept && phase_reg == PH_OBJECTS) begin
            header_reg <= header_next;
            value_reg  <= value_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_drain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DRAIN |-> objects_left_reg == 8'd0)
        else $error("draining with objects still outstanding");

    a_objects_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OBJECTS |-> objects_left_reg != 8'd0)
        else $error("parsing objects with none left");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_pos_reg < 5'(HDR_BYTES + RAW_VALUE_BYTES))
        else $error("byte position past largest object");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && last_byte |=> phase_reg == PH_COUNT && parsed_reg == 8'd0)
        else $error("block did not rearm after final byte");
`endif
endmodule

FILE: hw/rtl/orbd_out_queue.sv
`timescale 1ns / 1ps

module orbd_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  orbd_pkg::push_t   push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output orbd_pkg::result_t m_res
);
    import orbd_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    result_t            mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    // Pointer and occupancy update
    always_comb begin
        pop         = m_valid && m_ready;
        wr_ptr_p1   = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    // Room for the worst case of two results from the next byte
    assign room    = count_reg <= CNT_W'(QDEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_res   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> room)
        else $error("push without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd0 && !pop |=> $stable(count_reg))
        else $error("occupancy changed with no transaction");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != CNT_W'(QDEPTH) |->
            PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0])
        else $error("pointers disagree with occupancy");
`endif
endmodule

FILE: hw/rtl/object_record_deframer.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | byte_in, last_byte
// m_      | out       | m_valid / m_ready  | kind, object_id .. end_of_run
// cfg_    | in        | cfg_we             | cfg_wdata (max_objects)
//
// One byte is taken per cycle while s_ready is high; results are registered in a queue.
// A final byte that also completes an object yields two results in the same cycle.
// s_ready falls only while three or more results wait, which needs m_ready held low.
// s_ready depends only on the four-entry result queue occupancy, never on m_ready.
// Synchronous active-low reset; no clearing pass, the block accepts bytes right after reset.

module object_record_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [15:0] m_object_id,
    output logic [7:0]  m_object_type,
    output logic [7:0]  m_object_flags,
    output logic [63:0] m_value_low,
    output logic [63:0] m_value_high,
    output logic [7:0]  m_parsed_total,
    output logic        m_end_of_run
);
    import orbd_pkg::*;

    push_t   push;
    result_t res;
    logic    room;
    logic    in_accept;

    assign s_ready   = room;
    assign in_accept = s_valid && room;

    orbd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .byte_in   (s_byte_in),
        .last_byte (s_last_byte),
        .push      (push)
    );

    orbd_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    // Unpack the result transaction
    assign m_kind         = res.kind;
    assign m_object_id    = res.rec_id;
    assign m_object_type  = res.rec_type;
    assign m_object_flags = res.object_flags;
    assign m_value_low    = res.value_low;
    assign m_value_high   = res.value_high;
    assign m_parsed_total = res.parsed_total;
    assign m_end_of_run   = res.end_of_run;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import orbd_pkg::*;

    // Parse phases of the deframing predictor
    localparam logic [1:0] AWAIT_COUNT = 2'd0;
    localparam logic [1:0] IN_OBJECTS  = 2'd1;
    localparam logic [1:0] DRAINING    = 2'd2;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned NUM_PHASES  = 6;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        bit         typed;
        logic [7:0] total;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [15:0] m_object_id;
    logic [7:0]  m_object_type;
    logic [7:0]  m_object_flags;
    logic [63:0] m_value_low;
    logic [63:0] m_value_high;
    logic [7:0]  m_parsed_total;
    logic        m_end_of_run;

    // Predictor state
    logic [7:0]  clamp_max;
    logic [1:0]  parse_phase;
    logic [7:0]  objs_left;
    logic [4:0]  byte_pos;
    logic [31:0] hdr_word;
    logic [63:0] value_word [2];
    logic [7:0]  parsed_cnt;

    result_t     pending_results [$];
    result_t     step_results [$];
    logic [7:0]  frame_q [$];
    stim_row_t   directed_rows [24];

    bit          steady;
    int unsigned mismatches;
    int unsigned items_sent;

    object_record_deframer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_in      (s_byte_in),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_object_id    (m_object_id),
        .m_object_type  (m_object_type),
        .m_object_flags (m_object_flags),
        .m_value_low    (m_value_low),
        .m_value_high   (m_value_high),
        .m_parsed_total (m_parsed_total),
        .m_end_of_run   (m_end_of_run)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 50) begin
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        end
        mismatches++;
    endtask

    function automatic int unsigned value_len(input logic [7:0] ty);
        if (ty <= ANALOG_TYPE_MAX) begin
            return ANALOG_BYTES;
        end else if (ty <= BINARY_TYPE_MAX) begin
            return BINARY_BYTES;
        end
        return RAW_VALUE_BYTES;
    endfunction

    task automatic clear_parse();
        parse_phase   = AWAIT_COUNT;
        objs_left     = '0;
        byte_pos      = '0;
        hdr_word      = '0;
        value_word[0] = '0;
        value_word[1] = '0;
        parsed_cnt    = '0;
    endtask

    // Predict the results caused by one accepted byte into step_results
    task automatic deframe_byte(input logic [7:0] b, input logic fin);
        result_t     r;
        logic [7:0]  cnt;
        logic [7:0]  ty;
        int unsigned p;
        int unsigned k;
        step_results.delete();
        case (parse_phase)
            AWAIT_COUNT: begin
                cnt = (b > clamp_max) ? clamp_max : b;
                clear_parse();
                objs_left   = cnt;
                parse_phase = (cnt == 0) ? DRAINING : IN_OBJECTS;
            end
            IN_OBJECTS: begin
                p = byte_pos;
                if (p == 0) begin
                    hdr_word      = '0;
                    value_word[0] = '0;
                    value_word[1] = '0;
                end
                if (p < HDR_BYTES) begin
                    hdr_word[8*p +: 8] = b;
                end else begin
                    k = (p - HDR_BYTES) & 15;
                    value_word[k >> 3][8*(k & 7) +: 8] = b;
                end
                ty = hdr_word[23:16];
                if (p + 1 >= HDR_BYTES && p + 1 >= HDR_BYTES + value_len(ty)) begin
                    r              = '0;
                    r.kind         = KIND_OBJECT;
                    r.rec_id       = hdr_word[15:0];
                    r.rec_type     = ty;
                    r.object_flags = hdr_word[31:24];
                    r.value_low    = value_word[0];
                    r.value_high   = value_word[1];
                    r.end_of_run   = 1'b1;
                    step_results.insert(step_results.size(), r);
                    parsed_cnt = parsed_cnt + 8'd1;
                    objs_left  = objs_left - 8'd1;
                    byte_pos   = '0;
                    if (objs_left == 0) begin
                        parse_phase = DRAINING;
                    end
                end else begin
                    byte_pos = 5'(p + 1);
                end
            end
            default: begin
                // draining: byte ignored
            end
        endcase
        if (fin) begin
            if (step_results.size() > 0) begin
                step_results[0].end_of_run = 1'b0;
            end
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.parsed_total = parsed_cnt;
            r.end_of_run   = 1'b1;
            step_results.insert(step_results.size(), r);
            clear_parse();
        end
    endtask

    // Offer one byte, wait for the transaction, then log what it should cause
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input logic [7:0] total);
        int unsigned gap;
        result_t     r;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_byte_in   <= b;
        s_last_byte <= fin;
        do @(posedge aclk); while (s_ready !== 1'b1);
        deframe_byte(b, fin);
        if (typed) begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.parsed_total = total;
            r.end_of_run   = 1'b1;
            step_results   = '{r};
        end
        foreach (step_results[j]) begin
            pending_results.insert(pending_results.size(), step_results[j]);
        end
        items_sent++;
    endtask

    // Drop valid and let the block go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_max_objects(input logic [7:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        clamp_max = v;
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(0, 2));
            1: return 8'($urandom_range(3, 5));
            2: return 8'($urandom_range(6, 255));
            3: return 8'($urandom_range(0, 7));
            default: begin
                case ($urandom_range(0, 3))
                    0: return ANALOG_TYPE_MAX;
                    1: return BINARY_TYPE_MAX;
                    2: return 8'd6;
                    default: return 8'd255;
                endcase
            end
        endcase
    endfunction

    // Append the first keep bytes of an object of type ty
    task automatic add_object(input logic [7:0] ty, input int unsigned keep);
        logic [7:0]  obj [$];
        obj.insert(obj.size(), 8'($urandom));
        obj.insert(obj.size(), 8'($urandom));
        obj.insert(obj.size(), ty);
        obj.insert(obj.size(), 8'($urandom));
        repeat (value_len(ty)) obj.insert(obj.size(), 8'($urandom));
        for (int unsigned j = 0; j < keep; j++) begin
            frame_q.insert(frame_q.size(), obj[j]);
        end
    endtask

    // One buffer: mostly well-formed with random content, some noise
    task automatic build_frame();
        logic [7:0]  cnt;
        logic [7:0]  eff;
        logic [7:0]  ty;
        int unsigned nobj;
        frame_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) frame_q.insert(frame_q.size(), 8'($urandom));
        end else begin
            cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            frame_q.insert(frame_q.size(), cnt);
            eff  = (cnt > clamp_max) ? clamp_max : cnt;
            nobj = (eff > 5) ? 5 : eff;
            repeat (nobj) begin
                ty = pick_type();
                add_object(ty, HDR_BYTES + value_len(ty));
            end
            case ($urandom_range(0, 3))
                1: repeat ($urandom_range(1, 3)) frame_q.insert(frame_q.size(), 8'($urandom));
                2: begin
                    // truncated object at the end of the buffer
                    ty = pick_type();
                    add_object(ty, $urandom_range(1, HDR_BYTES + value_len(ty) - 1));
                end
                default: begin
                    // final byte is the last byte of the last object, or the count byte if there is none
                end
            endcase
        end
    endtask

    // Result side ready: random stall per result, none in steady stretches
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid === 1'b1));
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", m_kind, '0);
            end else begin
                w = pending_results.pop_front();
                if (m_kind !== w.kind)
                    report_mismatch("kind", m_kind, w.kind);
                if (m_object_id !== w.rec_id)
                    report_mismatch("rec_id", m_object_id, w.rec_id);
                if (m_object_type !== w.rec_type)
                    report_mismatch("rec_type", m_object_type, w.rec_type);
                if (m_object_flags !== w.object_flags)
                    report_mismatch("object_flags", m_object_flags, w.object_flags);
                if (m_value_low !== w.value_low)
                    report_mismatch("value_low", m_value_low, w.value_low);
                if (m_value_high !== w.value_high)
                    report_mismatch("value_high", m_value_high, w.value_high);
                if (m_parsed_total !== w.parsed_total)
                    report_mismatch("parsed_total", m_parsed_total, w.parsed_total);
                if (m_end_of_run !== w.end_of_run)
                    report_mismatch("end_of_run", m_end_of_run, w.end_of_run);
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned quota;
        logic [7:0]  lim;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_byte_in   = '0;
        s_last_byte = 1'b0;
        steady      = 1'b0;
        mismatches  = 0;
        items_sent  = 0;
        clamp_max   = MAX_OBJECTS_RESET;
        clear_parse();

        directed_rows = '{
            // count byte that is also the final byte
            '{8'h00, 1'b1, 1'b1, 8'd0},
            // two objects, the second completing on the final byte
            '{8'h02, 1'b0, 1'b0, 8'd0},
            '{8'h00, 1'b0, 1'b0, 8'd0}, '{8'h00, 1'b0, 1'b0, 8'd0},
            '{8'h00, 1'b0, 1'b0, 8'd0}, '{8'h00, 1'b0, 1'b0, 8'd0},
            '{8'hFF, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0},
            '{8'hFF, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0},
            '{8'hFF, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0},
            '{8'h05, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0},
            '{8'hA5, 1'b1, 1'b0, 8'd0},
            // raw object cut short by the final byte: dropped
            '{8'h01, 1'b0, 1'b0, 8'd0},
            '{8'h34, 1'b0, 1'b0, 8'd0}, '{8'h12, 1'b0, 1'b0, 8'd0},
            '{8'h06, 1'b0, 1'b0, 8'd0}, '{8'h80, 1'b0, 1'b0, 8'd0},
            '{8'h11, 1'b0, 1'b0, 8'd0}, '{8'h22, 1'b1, 1'b1, 8'd0},
            // zero count, trailing byte ignored
            '{8'h00, 1'b0, 1'b0, 8'd0},
            '{8'h7E, 1'b1, 1'b1, 8'd0}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].typed,
                      directed_rows[i].total);
        end

        // Random buffers over several clamp settings
        for (int unsigned ph_idx = 0; ph_idx < NUM_PHASES; ph_idx++) begin
            case (ph_idx)
                0: lim = 8'd255;
                1: lim = 8'd0;
                2: lim = 8'd1;
                3: lim = 8'($urandom_range(2, 254));
                4: lim = 8'd3;
                default: lim = 8'd255;
            endcase
            settle();
            write_max_objects(lim);
            quota = (ph_idx + 1) * ITEM_TARGET / NUM_PHASES;
            while (items_sent < quota) begin
                build_frame();
                steady = ($urandom_range(0, 4) == 0);
                foreach (frame_q[j]) begin
                    send_byte(frame_q[j], j == frame_q.size() - 1, 1'b0, 8'd0);
                end
            end
        end

        // Let the last results drain
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results left over", pending_results.size(), '0);
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
